>>> hw/rtl/setrig_pkg.sv
// Shared types and constants for the scheduled event trigger timer.
package setrig_pkg;

  // Default sizes of the schedule table and of one time value
  localparam int unsigned MaxEntriesDef = 16;
  localparam int unsigned TimeBitsDef   = 32;

  // Fixed field widths of the stream beats and the config port
  localparam int unsigned OpW        = 2;
  localparam int unsigned IdxW       = 4;
  localparam int unsigned EntryTimeW = 32;
  localparam int unsigned CountW     = 32;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 5;
  localparam int unsigned EntryCntW  = 5;
  localparam int unsigned InDataW    = 40;  // 36 payload bits padded to bytes
  localparam int unsigned OutDataW   = 40;  // 38 payload bits padded to bytes

  // Operation codes carried in the input tuser
  typedef enum logic [OpW-1:0] {
    OP_TICK  = 2'd0,
    OP_WRITE = 2'd1,
    OP_START = 2'd2
  } op_e;

  // Configuration register indexes
  typedef enum logic [CfgIdxW-1:0] {
    CFG_RELATIVE_MODE = 2'd0,
    CFG_RECYCLE_EN    = 2'd1,
    CFG_ENTRY_COUNT   = 2'd2
  } cfg_idx_e;

  // One accepted input beat
  typedef struct packed {
    logic [OpW-1:0]        op;
    logic [IdxW-1:0]       entry_index;
    logic [EntryTimeW-1:0] entry_time;
  } item_t;

  // One result beat
  typedef struct packed {
    logic              trigger;
    logic [CountW-1:0] fire_count;
    logic              fire_index_valid;
    logic [IdxW-1:0]   fire_index;
  } res_t;

endpackage

>>> hw/rtl/setrig_table.sv
// Schedule table: register file with one write port and one indexed read port.
module setrig_table #(
  parameter int unsigned MAX_ENTRIES = setrig_pkg::MaxEntriesDef,
  parameter int unsigned TIME_BITS   = setrig_pkg::TimeBitsDef,
  localparam int unsigned AddrW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                 clk_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  logic [TIME_BITS-1:0] wr_data_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  output logic [TIME_BITS-1:0] rd_data_o,
  output logic [TIME_BITS-1:0] entry0_o
);

  logic [TIME_BITS-1:0] mem_q [MAX_ENTRIES];

  // No reset: entries are undefined until written
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  assign rd_data_o = mem_q[rd_addr_i];
  assign entry0_o  = mem_q[0];

endmodule

>>> hw/rtl/setrig_sched.sv
// Schedule state: countdown, slot pointers, fire status and config registers.
module setrig_sched
  import setrig_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = setrig_pkg::MaxEntriesDef,
  parameter int unsigned TIME_BITS   = setrig_pkg::TimeBitsDef,
  localparam int unsigned AddrW      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [setrig_pkg::CfgIdxW-1:0]    cfg_idx_i,
  input  logic [setrig_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                              en_i,
  input  setrig_pkg::item_t                 item_i,
  output setrig_pkg::res_t                  res_o,
  output logic                              tbl_wr_en_o,
  output logic [AddrW-1:0]                  tbl_wr_addr_o,
  output logic [TIME_BITS-1:0]              tbl_wr_data_o,
  output logic [AddrW-1:0]                  tbl_rd_addr_o,
  input  logic [TIME_BITS-1:0]              tbl_rd_data_i,
  input  logic [TIME_BITS-1:0]              tbl_entry0_i
);

  localparam int unsigned SlotW = $clog2(MAX_ENTRIES + 1);
  localparam int unsigned CntW  = (SlotW > EntryCntW) ? SlotW : EntryCntW;

  logic                 relative_q, recycle_q;
  logic [EntryCntW-1:0] entry_count_q;

  logic [TIME_BITS-1:0] countdown_q, countdown_d;
  logic [TIME_BITS-1:0] prev_time_q, prev_time_d;
  logic [SlotW-1:0]     next_slot_q, next_slot_d;
  logic                 restart_q, restart_d;   // restart slot is 0 or 1
  logic                 running_q, running_d;
  logic [CountW-1:0]    fires_q, fires_d;
  logic [IdxW-1:0]      last_idx_q, last_idx_d;
  logic                 any_fired_q, any_fired_d;
  logic                 trigger;

  logic [CntW-1:0]      ec_ext, n_act;
  logic                 more_slots, can_recycle;
  logic [AddrW-1:0]     load_addr;
  logic [TIME_BITS-1:0] base_time;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relative_q    <= 1'b0;
      recycle_q     <= 1'b0;
      entry_count_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_RELATIVE_MODE: relative_q    <= cfg_data_i[0];
        CFG_RECYCLE_EN:    recycle_q     <= cfg_data_i[0];
        CFG_ENTRY_COUNT:   entry_count_q <= cfg_data_i[EntryCntW-1:0];
        default: ;
      endcase
    end
  end

  // Active entry count, clamped to the table depth
  assign ec_ext = CntW'(entry_count_q);
  assign n_act  = (ec_ext > CntW'(MAX_ENTRIES)) ? CntW'(MAX_ENTRIES) : ec_ext;

  assign more_slots  = CntW'(next_slot_q) < n_act;
  assign can_recycle = recycle_q && (CntW'(restart_q) < n_act);
  assign load_addr   = more_slots ? next_slot_q[AddrW-1:0] : AddrW'(restart_q);
  // Absolute mode restarts its time reference on recycle
  assign base_time   = more_slots ? prev_time_q : '0;

  assign tbl_rd_addr_o = load_addr;
  assign tbl_wr_en_o   = en_i && (item_i.op == OP_WRITE) &&
                         (32'(item_i.entry_index) < MAX_ENTRIES);
  assign tbl_wr_addr_o = AddrW'(item_i.entry_index);
  assign tbl_wr_data_o = TIME_BITS'(item_i.entry_time);

  always_comb begin
    countdown_d = countdown_q;
    prev_time_d = prev_time_q;
    next_slot_d = next_slot_q;
    restart_d   = restart_q;
    running_d   = running_q;
    fires_d     = fires_q;
    last_idx_d  = last_idx_q;
    any_fired_d = any_fired_q;
    trigger     = 1'b0;
    if (en_i) begin
      case (item_i.op)
        OP_TICK: begin
          if (running_q) begin
            if (countdown_q != '0) begin
              countdown_d = countdown_q - 1'b1;
            end else begin
              trigger     = 1'b1;
              fires_d     = fires_q + 1'b1;
              any_fired_d = 1'b1;
              last_idx_d  = IdxW'(next_slot_q - 1'b1);
              if (more_slots || can_recycle) begin
                if (relative_q) begin
                  countdown_d = tbl_rd_data_i;
                end else begin
                  countdown_d = tbl_rd_data_i - base_time;
                  prev_time_d = tbl_rd_data_i;
                end
                next_slot_d = SlotW'(load_addr) + 1'b1;
              end else begin
                running_d = 1'b0;
              end
            end
          end
        end
        OP_START: begin
          fires_d     = '0;
          any_fired_d = 1'b0;
          last_idx_d  = '0;
          next_slot_d = SlotW'(1);
          restart_d   = 1'b0;
          prev_time_d = '0;
          countdown_d = '0;
          running_d   = (n_act != '0);
          if (n_act != '0) begin
            if (tbl_entry0_i == '0) begin
              restart_d = 1'b1;   // zero entry fires once, skipped on recycle
            end else begin
              countdown_d = tbl_entry0_i;
              prev_time_d = tbl_entry0_i;
            end
          end
        end
        default: ;  // writes go to the table; unused code does nothing
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      countdown_q <= '0;
      prev_time_q <= '0;
      next_slot_q <= '0;
      restart_q   <= 1'b0;
      running_q   <= 1'b0;
      fires_q     <= '0;
      last_idx_q  <= '0;
      any_fired_q <= 1'b0;
    end else begin
      countdown_q <= countdown_d;
      prev_time_q <= prev_time_d;
      next_slot_q <= next_slot_d;
      restart_q   <= restart_d;
      running_q   <= running_d;
      fires_q     <= fires_d;
      last_idx_q  <= last_idx_d;
      any_fired_q <= any_fired_d;
    end
  end

  assign res_o.trigger          = trigger;
  assign res_o.fire_count       = fires_d;
  assign res_o.fire_index_valid = any_fired_d;
  assign res_o.fire_index       = any_fired_d ? last_idx_d : '0;

endmodule

>>> hw/rtl/scheduled_event_trigger_timer_core.sv
// Top level of the scheduled event trigger timer: stream ports and beat registers.
//
// Sample-tick event timer. Each input beat is a tick, a table write or a start
// (operation in s_axis_tuser) and produces exactly one result beat with the
// trigger flag, the fire count and the index of the last fired entry. Beats
// are taken at one per clock unless the output stalls: a beat lands in the
// input register, then the schedule state updates (one table read, one
// subtract, one decrement) and the result is captured in the output
// register, so throughput is one beat per cycle while m_axis_tready is
// high. The output register holds a result under back-pressure and the input
// register keeps accepting as long as the result moves on. Configuration
// writes take effect at once and belong in idle periods; relative_mode and
// recycle_enable are read at every load, so changes apply at the next fire.
// The table has no reset; start only after entry 0 and all counted entries
// have been written.
module scheduled_event_trigger_timer_core
  import setrig_pkg::*;
#(
  parameter int unsigned MAX_ENTRIES = setrig_pkg::MaxEntriesDef,
  parameter int unsigned TIME_BITS   = setrig_pkg::TimeBitsDef
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // config write port
  input  logic                             cfg_we_i,
  input  logic [setrig_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [setrig_pkg::CfgDataW-1:0]  cfg_data_i,
  // input stream
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [3:0] entry_index, [35:4] entry_time, [39:36] zero
  input  logic [setrig_pkg::InDataW-1:0]   s_axis_tdata,
  // [1:0] operation
  input  logic [setrig_pkg::OpW-1:0]       s_axis_tuser,
  // result stream
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [0] trigger, [32:1] fire_count, [33] fire_index_valid,
  // [37:34] fire_index, [39:38] zero
  output logic [setrig_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned AddrW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  logic  in_valid_q;
  item_t in_item_q;
  logic  out_valid_q;
  res_t  out_res_q;
  res_t  res;
  logic  advance;

  logic                 tbl_wr_en;
  logic [AddrW-1:0]     tbl_wr_addr, tbl_rd_addr;
  logic [TIME_BITS-1:0] tbl_wr_data, tbl_rd_data, tbl_entry0;

  // The held beat is processed whenever the result slot is free or draining
  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_item_q.op          <= s_axis_tuser;
      in_item_q.entry_index <= s_axis_tdata[IdxW-1:0];
      in_item_q.entry_time  <= s_axis_tdata[IdxW +: EntryTimeW];
    end
  end

  setrig_sched #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TIME_BITS   (TIME_BITS)
  ) u_sched (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .en_i          (in_valid_q && advance),
    .item_i        (in_item_q),
    .res_o         (res),
    .tbl_wr_en_o   (tbl_wr_en),
    .tbl_wr_addr_o (tbl_wr_addr),
    .tbl_wr_data_o (tbl_wr_data),
    .tbl_rd_addr_o (tbl_rd_addr),
    .tbl_rd_data_i (tbl_rd_data),
    .tbl_entry0_i  (tbl_entry0)
  );

  setrig_table #(
    .MAX_ENTRIES (MAX_ENTRIES),
    .TIME_BITS   (TIME_BITS)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (tbl_wr_en),
    .wr_addr_i (tbl_wr_addr),
    .wr_data_i (tbl_wr_data),
    .rd_addr_i (tbl_rd_addr),
    .rd_data_o (tbl_rd_data),
    .entry0_o  (tbl_entry0)
  );

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && in_valid_q) begin
      out_res_q <= res;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_res_q.fire_index, out_res_q.fire_index_valid,
                          out_res_q.fire_count, out_res_q.trigger};

endmodule

>>> tb/scheduled_event_trigger_timer_core_tb.sv
// Self-checking stream testbench for the scheduled event trigger timer core.
module scheduled_event_trigger_timer_core_tb;
  import setrig_pkg::*;

  // Operation code 3 is unused; the block must answer it with a plain status beat
  localparam logic [OpW-1:0] OpUnused = 2'd3;
  localparam int unsigned NumPhases    = 10;
  localparam int unsigned PhaseBeats   = 95;
  localparam int unsigned SqueezePhase = 2;    // phase with the long output stall
  localparam int unsigned SqueezeLen   = 300;  // cycles of held-off m_axis_tready
  localparam int unsigned SettleCycles = 4;    // input and output registers plus margin

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic                 cfg_we_i      = 1'b0;
  logic [CfgIdxW-1:0]   cfg_idx_i     = '0;
  logic [CfgDataW-1:0]  cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [InDataW-1:0]   s_axis_tdata  = '0;
  logic [OpW-1:0]       s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [OutDataW-1:0]  m_axis_tdata;

  scheduled_event_trigger_timer_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #4 clk_i = ~clk_i;

  // ---------------------------------------------------------------------------
  // Timer model: own copy of the configuration and the schedule state
  // ---------------------------------------------------------------------------
  bit                    rel_mode;
  bit                    recyc_en;
  logic [EntryCntW-1:0]  ent_cnt;

  logic [31:0] sched_tbl [16];
  logic [31:0] cdown;
  logic [4:0]  nxt_slot;
  logic [3:0]  rst_slot;
  logic [31:0] prev_t;
  bit          armed;
  logic [31:0] fire_cnt;
  logic [3:0]  last_idx;
  bit          fired_any;

  item_t sample_beats [$];    // input beats waiting for the driver
  res_t  expected_status [$]; // predicted result beats, oldest first

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned phase_no;
  int unsigned mismatch_cnt;

  // register settings of the random phases: relative_mode, recycle_enable, entry_count
  int unsigned phase_cfg [NumPhases][3] = '{
    '{1, 1, 16}, '{0, 1, 1}, '{1, 0, 5}, '{0, 0, 16}, '{1, 1, 31},
    '{0, 1, 8},  '{1, 1, 2}, '{0, 0, 0}, '{1, 1, 1},  '{0, 1, 31}
  };

  // entries above the table size act as a full table
  function automatic int unsigned live_entries();
    return (ent_cnt > 16) ? 16 : ent_cnt;
  endfunction

  // load the interval of one slot; absolute times become a difference mod 2^32
  function automatic void load_slot(logic [4:0] s);
    logic [31:0] t;
    t = sched_tbl[s[3:0]];
    if (rel_mode) begin
      cdown = t;
    end else begin
      cdown  = t - prev_t;
      prev_t = t;
    end
    nxt_slot = s + 5'd1;
  endfunction

  // advance the timer model by one beat and return the status it reports
  function automatic res_t timer_step(item_t b);
    res_t        r;
    bit          fired;
    int unsigned n;
    fired = 1'b0;
    n     = live_entries();
    case (b.op)
      OP_TICK: begin
        if (armed) begin
          if (cdown != 0) begin
            cdown = cdown - 32'd1;
          end else begin
            fired     = 1'b1;
            fire_cnt  = fire_cnt + 32'd1;
            fired_any = 1'b1;
            last_idx  = 4'(nxt_slot - 5'd1);
            if (nxt_slot < n) begin
              load_slot(nxt_slot);
            end else if (recyc_en && rst_slot < n) begin
              // recycle: absolute reference restarts at zero
              if (!rel_mode) prev_t = '0;
              load_slot({1'b0, rst_slot});
            end else begin
              armed = 1'b0;
            end
          end
        end
      end
      OP_WRITE: begin
        sched_tbl[b.entry_index] = b.entry_time;
      end
      OP_START: begin
        fire_cnt  = '0;
        fired_any = 1'b0;
        last_idx  = '0;
        nxt_slot  = 5'd1;
        rst_slot  = '0;
        prev_t    = '0;
        cdown     = '0;
        armed     = (n != 0);
        if (armed) begin
          // a zero first entry fires on the next tick and is skipped on recycle
          if (sched_tbl[0] == 0) begin
            rst_slot = 4'd1;
          end else begin
            cdown  = sched_tbl[0];
            prev_t = sched_tbl[0];
          end
        end
      end
      default: ;
    endcase
    r.trigger          = fired;
    r.fire_count       = fire_cnt;
    r.fire_index_valid = fired_any;
    r.fire_index       = fired_any ? last_idx : 4'd0;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offers queued beats, holds each until accepted, predicts on accept
  // ---------------------------------------------------------------------------
  item_t cur_beat;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) expected_status.push_back(timer_step(cur_beat));
      // free to present a new beat when nothing is pending or the last one moved
      if (!s_axis_tvalid || s_axis_tready) begin
        if (sample_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_beat      = sample_beats.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {4'b0, cur_beat.entry_time, cur_beat.entry_index};
          s_axis_tuser  <= cur_beat.op;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: random back-pressure, one long stall, field-by-field compare
  // ---------------------------------------------------------------------------
  res_t        got_status;
  res_t        want_status;
  int unsigned stall_left;
  bit          squeeze_done;

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatch_cnt++;
    end
  endtask

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_status.trigger          = m_axis_tdata[0];
        got_status.fire_count       = m_axis_tdata[32:1];
        got_status.fire_index_valid = m_axis_tdata[33];
        got_status.fire_index       = m_axis_tdata[37:34];
        if (expected_status.size() == 0) begin
          $display("%0t: result beat with nothing expected: expected none, actual %h",
                   $time, m_axis_tdata);
          mismatch_cnt++;
        end else begin
          want_status = expected_status.pop_front();
          check_field("trigger", 32'(want_status.trigger), 32'(got_status.trigger));
          check_field("fire_count", want_status.fire_count, got_status.fire_count);
          check_field("fire_index_valid", 32'(want_status.fire_index_valid),
                      32'(got_status.fire_index_valid));
          check_field("fire_index", 32'(want_status.fire_index),
                      32'(got_status.fire_index));
        end
      end
      // one long hold-off so the pipeline fills and s_axis_tready drops
      if (phase_no == SqueezePhase && !squeeze_done) begin
        stall_left   = SqueezeLen;
        squeeze_done = 1'b1;
      end
      if (stall_left != 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and phase control
  // ---------------------------------------------------------------------------
  task automatic push_beat(logic [OpW-1:0] op, logic [IdxW-1:0] idx, logic [31:0] tm);
    item_t b;
    b.op          = op;
    b.entry_index = idx;
    b.entry_time  = tm;
    sample_beats.push_back(b);
  endtask

  // config writes happen only with the pipeline empty
  task automatic write_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    case (idx)
      CFG_RELATIVE_MODE: rel_mode = val[0];
      CFG_RECYCLE_EN:    recyc_en = val[0];
      CFG_ENTRY_COUNT:   ent_cnt  = val;
      default: ;
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // wait until every queued beat is in and every predicted result is out
  task automatic drain();
    do @(negedge clk_i);
    while (sample_beats.size() != 0 || s_axis_tvalid || expected_status.size() != 0);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // mostly fresh well-formed schedules followed by tick runs, with some noise
  task automatic fill_phase(int unsigned target);
    int unsigned n;
    int unsigned k;
    int unsigned run_len;
    logic [31:0] t;
    n = live_entries();
    while (sample_beats.size() < target) begin
      if ($urandom_range(9) < 7) begin
        t = $urandom_range(1) ? 32'd0 : 32'($urandom_range(1, 4));
        for (k = 0; k < n; k++) begin
          push_beat(OP_WRITE, 4'(k), t);
          // absolute times stay sorted and unique, intervals may be zero
          t = rel_mode ? 32'($urandom_range(0, 6)) : t + 32'($urandom_range(1, 6));
        end
      end
      push_beat(OP_START, 4'($urandom_range(15)), $urandom);
      run_len = $urandom_range(4, 50);
      for (k = 0; k < run_len; k++) begin
        case ($urandom_range(49))
          0:       push_beat(OpUnused, 4'($urandom_range(15)), $urandom);
          1, 2:    push_beat(OP_WRITE, 4'($urandom_range(15)), $urandom);
          3:       push_beat(OP_START, 4'($urandom_range(15)), $urandom);
          default: push_beat(OP_TICK, 4'($urandom_range(15)), $urandom);
        endcase
      end
    end
  endtask

  initial begin
    int unsigned p;
    int unsigned k;
    send_idle_pct = 15;
    recv_idle_pct = 66;
    phase_no      = 0;
    mismatch_cnt  = 0;
    stall_left    = 0;
    squeeze_done  = 1'b0;
    rel_mode      = 1'b0;
    recyc_en      = 1'b0;
    ent_cnt       = '0;
    armed         = 1'b0;
    cdown         = '0;
    nxt_slot      = '0;
    rst_slot      = '0;
    prev_t        = '0;
    fire_cnt      = '0;
    last_idx      = '0;
    fired_any     = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: tick before any start, unused op, start with an empty table,
    // then load every slot (zero first entry, all-ones last entry)
    @(negedge clk_i);
    push_beat(OP_TICK, 4'hF, 32'hFFFF_FFFF);
    push_beat(OpUnused, 4'hF, 32'hFFFF_FFFF);
    push_beat(OP_START, 4'h0, 32'h0);
    for (k = 0; k < 15; k++) push_beat(OP_WRITE, 4'(k), 32'(3 * k));
    push_beat(OP_WRITE, 4'hF, 32'hFFFF_FFFF);
    drain();

    // Directed: absolute schedule 0,3,6 with recycle, zero entry skipped on wrap
    write_cfg(CFG_RELATIVE_MODE, 5'd0);
    write_cfg(CFG_RECYCLE_EN, 5'd1);
    write_cfg(CFG_ENTRY_COUNT, 5'd3);
    @(negedge clk_i);
    push_beat(OP_START, 4'h0, 32'h0);
    for (k = 0; k < 9; k++) push_beat(OP_TICK, 4'h0, 32'h0);
    drain();

    // Random phases across register settings and idle patterns
    for (p = 0; p < NumPhases; p++) begin
      write_cfg(CFG_RELATIVE_MODE, CfgDataW'(phase_cfg[p][0]));
      write_cfg(CFG_RECYCLE_EN, CfgDataW'(phase_cfg[p][1]));
      write_cfg(CFG_ENTRY_COUNT, CfgDataW'(phase_cfg[p][2]));
      @(negedge clk_i);
      phase_no = p + 1;
      if (p < 3) begin
        send_idle_pct = 15;
        recv_idle_pct = 66;
      end else if (p < 7) begin
        send_idle_pct = 66;
        recv_idle_pct = 15;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      fill_phase(PhaseBeats);
      drain();
    end

    repeat (10) @(posedge clk_i);
    if (mismatch_cnt == 0 && expected_status.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  // watchdog, far beyond the slowest legal run
  initial begin
    #(8 * 400000);
    $display("Verification failed");
    $finish;
  end

endmodule

>>> scheduled_event_trigger_timer_core.f
hw/rtl/setrig_pkg.sv
hw/rtl/setrig_table.sv
hw/rtl/setrig_sched.sv
hw/rtl/scheduled_event_trigger_timer_core.sv
tb/scheduled_event_trigger_timer_core_tb.sv
